// File: rtl/core/rpn_pkg.sv
// RPN calculator package: operation and status codes, shared widths and the
// controller-to-datapath command struct. No dependencies.
`default_nettype none
package rpn_pkg;
  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned FuncW = 5;
  localparam int unsigned StatW = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned DepthW = 7;

  localparam logic [FuncW-1:0] F_PUSH = 5'd0, F_TRUE = 5'd1, F_FALSE = 5'd2,
    F_NOT = 5'd3, F_PRINT = 5'd4, F_CLEAR = 5'd5, F_DROP = 5'd6, F_DUP = 5'd7,
    F_SWAP = 5'd8, F_ADD = 5'd9, F_SUB = 5'd10, F_MUL = 5'd11, F_DIV = 5'd12,
    F_MOD = 5'd13, F_LT = 5'd14, F_GT = 5'd15, F_LE = 5'd16, F_GE = 5'd17,
    F_EQ = 5'd18;

  localparam logic [StatW-1:0] ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_NOT_INT = 3'd2,
    ST_NOT_BOOL = 3'd3, ST_OVERFLOW = 3'd4, ST_DIV_ZERO = 3'd5;

  // datapath commands
  localparam logic [2:0] DP_NONE = 3'd0, DP_RD_TOP = 3'd1, DP_RD_SEC = 3'd2,
    DP_WRITE = 3'd3, DP_ALU = 3'd4, DP_DIV = 3'd5;

  // write data selectors
  localparam logic [2:0] WS_PUSH = 3'd0, WS_CONST = 3'd1, WS_NOTB = 3'd2,
    WS_ALU = 3'd3, WS_A = 3'd4, WS_B = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] wsel;
    logic       wsecond;  // write at sp-2 instead of sp (relative to cmd sp)
    logic       wtag;
    logic       capture;  // latch the input beat
  } dp_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       b_zero;
    logic       ta;
    logic       tb;
  } dp_stat_t;
endpackage
`default_nettype wire

// File: rtl/core/rpn_divider.sv
// Radix-2 signed divider, one quotient bit per cycle, truncating.
// Depends on rpn_pkg.
`default_nettype none
module rpn_divider import rpn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DataW-1:0] a,
  input  wire logic [DataW-1:0] b,
  output logic                  done,
  output logic [DataW-1:0]      quot,
  output logic [DataW-1:0]      rem
);
  localparam int unsigned CntW = $clog2(DataW + 1);
  logic [DataW-1:0] q_r, d_r;
  logic [DataW:0]   r_r;
  logic [CntW-1:0]  cnt_r;
  logic             busy_r, done_r, qneg_r, rneg_r;
  logic [DataW:0]   trial;
  logic [DataW:0]   shifted;

  assign shifted = {r_r[DataW-1:0], q_r[DataW-1]};
  assign trial = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DataW);
        q_r    <= a[DataW-1] ? (~a + 1'b1) : a;
        d_r    <= b[DataW-1] ? (~b + 1'b1) : b;
        r_r    <= '0;
        qneg_r <= a[DataW-1] ^ b[DataW-1];
        rneg_r <= a[DataW-1];
      end else if (busy_r) begin
        if (trial[DataW]) begin
          r_r <= shifted;
          q_r <= {q_r[DataW-2:0], 1'b0};
        end else begin
          r_r <= trial;
          q_r <= {q_r[DataW-2:0], 1'b1};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = qneg_r ? (~q_r + 1'b1) : q_r;
  assign rem  = rneg_r ? (~r_r[DataW-1:0] + 1'b1) : r_r[DataW-1:0];
endmodule
`default_nettype wire

// File: rtl/core/rpn_datapath.sv
// RPN datapath: stack memory, operand registers, ALU and divider.
// Depends on rpn_pkg and rpn_divider.
`default_nettype none
module rpn_datapath import rpn_pkg::*; #(
  parameter int unsigned StackDepth = DefStackDepth
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dp_cmd_t                 cmd,
  input  wire logic [FuncW-1:0]        in_func,
  input  wire logic [DataW-1:0]        in_value,
  input  wire logic [$clog2(StackDepth+1)-1:0] sp,
  output dp_stat_t                     stat,
  output logic [DataW-1:0]             top_value,
  output logic                         top_tag
);
  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned SpW = $clog2(StackDepth + 1);

  logic [DataW:0]   mem [StackDepth];
  logic [DataW:0]   rd_r;
  logic [DataW-1:0] a_r, b_r, alu_r, pv_r;
  logic             ta_r, tb_r;
  logic [FuncW-1:0] func_r;
  logic [SpW-1:0]   raddr, waddr;
  logic [DataW-1:0] wdata;
  logic             div_done;
  logic [DataW-1:0] quot, rem, alu_nxt;
  logic             lt;

  // read address: top = sp-1, second = sp-2
  assign raddr = (cmd.op == DP_RD_SEC) ? sp - SpW'(2) : sp - SpW'(1);
  assign waddr = cmd.wsecond ? sp - SpW'(2) : sp;
  assign lt = $signed(a_r) < $signed(b_r);

  always_comb begin
    case (func_r)
      F_ADD:   alu_nxt = a_r + b_r;
      F_SUB:   alu_nxt = a_r - b_r;
      F_MUL:   alu_nxt = a_r * b_r;
      F_LT:    alu_nxt = DataW'(lt);
      F_GT:    alu_nxt = DataW'(!lt && a_r != b_r);
      F_LE:    alu_nxt = DataW'(lt || a_r == b_r);
      F_GE:    alu_nxt = DataW'(!lt);
      F_EQ:    alu_nxt = DataW'(a_r == b_r && ta_r == tb_r);
      default: alu_nxt = '0;
    endcase
  end

  always_comb begin
    case (cmd.wsel)
      WS_PUSH:  wdata = pv_r;
      WS_CONST: wdata = DataW'(func_r == F_TRUE);
      WS_NOTB:  wdata = DataW'(b_r == '0);
      WS_ALU:   wdata = alu_r;
      WS_A:     wdata = a_r;
      WS_B:     wdata = b_r;
      default:  wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_WRITE) mem[waddr[AW-1:0]] <= {cmd.wtag, wdata};
    rd_r <= mem[raddr[AW-1:0]];
  end

  // rd_r holds data of the read issued last cycle; controller latches via op
  logic [2:0] prev_op_r;
  always_ff @(posedge clk) begin
    if (!rst_n) prev_op_r <= DP_NONE;
    else        prev_op_r <= cmd.op;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      pv_r   <= in_value;
    end
    if (prev_op_r == DP_RD_TOP) begin
      b_r  <= rd_r[DataW-1:0];
      tb_r <= rd_r[DataW];
    end
    if (prev_op_r == DP_RD_SEC) begin
      a_r  <= rd_r[DataW-1:0];
      ta_r <= rd_r[DataW];
    end
    if (cmd.op == DP_ALU) alu_r <= alu_nxt;
    if (div_done) alu_r <= (func_r == F_DIV) ? quot : rem;
  end

  rpn_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.op == DP_DIV),
    .a(a_r), .b(b_r), .done(div_done), .quot(quot), .rem(rem)
  );

  assign stat.div_done = div_done;
  assign stat.b_zero   = (b_r == '0);
  assign stat.ta       = ta_r;
  assign stat.tb       = tb_r;
  assign top_value     = b_r;
  assign top_tag       = tb_r;
endmodule
`default_nettype wire

// File: rtl/core/rpn_ctrl.sv
// RPN controller: sequences stack reads, ALU/divider use and writes, keeps
// the stack pointer and forms the result beat. Depends on rpn_pkg.
`default_nettype none
module rpn_ctrl import rpn_pkg::*; #(
  parameter int unsigned StackDepth = DefStackDepth
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [FuncW-1:0] in_func,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [StatW-1:0]      out_status,
  output logic                  out_pvalid,
  output logic                  out_pbool,
  output logic [DataW-1:0]      out_pvalue,
  output logic [DepthW-1:0]     out_depth,
  output dp_cmd_t               cmd,
  output logic [$clog2(StackDepth+1)-1:0] sp,
  input  wire dp_stat_t         stat,
  input  wire logic [DataW-1:0] top_value,
  input  wire logic             top_tag
);
  localparam int unsigned SpW = $clog2(StackDepth + 1);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RT = 4'd2, S_RTW = 4'd3,
    S_CHK1 = 4'd4, S_RSW = 4'd5, S_CHK2 = 4'd6, S_EXEC = 4'd7, S_DIVW = 4'd8,
    S_WR = 4'd9, S_SWP = 4'd10, S_OUT = 4'd11;

  logic [3:0]       st_r, st_nxt;
  logic [SpW-1:0]   sp_r, sp_nxt;
  logic [FuncW-1:0] f_r;
  logic [StatW-1:0] status_r, status_nxt;
  logic             pv_r, pv_nxt, ovld_r, ovld_nxt;
  logic             is_bin, is_cmp, full, out_free;

  assign full     = (sp_r == SpW'(StackDepth));
  assign is_bin   = (f_r >= F_ADD) && (f_r <= F_EQ);
  assign is_cmp   = (f_r >= F_LT) && (f_r <= F_EQ);
  assign out_free = !ovld_r || out_tready;

  always_comb begin
    st_nxt = st_r;
    sp_nxt = sp_r;
    status_nxt = status_r;
    pv_nxt = pv_r;
    ovld_nxt = ovld_r && !out_tready;
    cmd = '0;
    cmd.op = DP_NONE;
    case (st_r)
      S_IDLE: begin
        cmd.capture = in_tvalid && in_tready;
        if (in_tvalid && in_tready) begin
          status_nxt = ST_OK;
          pv_nxt = 1'b0;
          st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (f_r == F_PUSH || f_r == F_TRUE || f_r == F_FALSE) begin
          if (full) begin
            status_nxt = ST_OVERFLOW;
            st_nxt = S_OUT;
          end else begin
            cmd.op = DP_WRITE;
            cmd.wsel = (f_r == F_PUSH) ? WS_PUSH : WS_CONST;
            cmd.wtag = (f_r != F_PUSH);
            sp_nxt = sp_r + 1'b1;
            st_nxt = S_OUT;
          end
        end else if (f_r == F_CLEAR) begin
          sp_nxt = '0;
          st_nxt = S_OUT;
        end else if (f_r > F_EQ) begin
          st_nxt = S_OUT;
        end else if (sp_r == '0) begin
          if (f_r != F_PRINT) status_nxt = ST_EMPTY;
          st_nxt = S_OUT;
        end else if (f_r == F_DROP) begin
          sp_nxt = sp_r - 1'b1;
          st_nxt = S_OUT;
        end else if (f_r == F_DUP && full) begin
          status_nxt = ST_OVERFLOW;
          st_nxt = S_OUT;
        end else begin
          cmd.op = DP_RD_TOP;
          st_nxt = S_RT;
        end
      end
      S_RT: st_nxt = S_RTW;       // read data registers in memory
      S_RTW: st_nxt = S_CHK1;     // operand b latched
      S_CHK1: begin
        if (f_r == F_PRINT) begin
          pv_nxt = 1'b1;
          st_nxt = S_OUT;
        end else if (f_r == F_NOT) begin
          if (!top_tag) begin
            status_nxt = ST_NOT_BOOL;
            st_nxt = S_OUT;
          end else begin
            sp_nxt = sp_r - 1'b1;  // point at top, restore below
            st_nxt = S_WR;
          end
        end else if (f_r == F_DUP) begin
          cmd.op = DP_WRITE;
          cmd.wsel = WS_B;
          cmd.wtag = top_tag;
          sp_nxt = sp_r + 1'b1;
          st_nxt = S_OUT;
        end else if (is_bin && f_r != F_EQ && top_tag) begin
          status_nxt = ST_NOT_INT;
          st_nxt = S_OUT;
        end else if (sp_r == SpW'(1)) begin
          sp_nxt = '0;
          status_nxt = ST_EMPTY;
          st_nxt = S_OUT;
        end else begin
          cmd.op = DP_RD_SEC;
          st_nxt = S_RSW;
        end
      end
      S_RSW: st_nxt = S_CHK2;
      S_CHK2: st_nxt = S_EXEC;    // operand a latched
      S_EXEC: begin
        if (f_r == F_SWAP) begin
          cmd.op = DP_WRITE;
          cmd.wsel = WS_B;
          cmd.wtag = stat.tb;
          cmd.wsecond = 1'b1;
          sp_nxt = sp_r - 1'b1;
          st_nxt = S_SWP;
        end else if (f_r != F_EQ && stat.ta) begin
          sp_nxt = sp_r - 1'b1;
          status_nxt = ST_NOT_INT;
          st_nxt = S_OUT;
        end else if ((f_r == F_DIV || f_r == F_MOD) && stat.b_zero) begin
          sp_nxt = sp_r - SpW'(2);
          status_nxt = ST_DIV_ZERO;
          st_nxt = S_OUT;
        end else if (f_r == F_DIV || f_r == F_MOD) begin
          cmd.op = DP_DIV;
          st_nxt = S_DIVW;
        end else begin
          cmd.op = DP_ALU;
          st_nxt = S_WR;
        end
      end
      S_DIVW: if (stat.div_done) st_nxt = S_WR;
      S_SWP: begin
        cmd.op = DP_WRITE;
        cmd.wsel = WS_A;
        cmd.wtag = stat.ta;
        sp_nxt = sp_r + 1'b1;
        st_nxt = S_OUT;
      end
      S_WR: begin
        if (f_r == F_NOT) begin
          cmd.op = DP_WRITE;
          cmd.wsel = WS_NOTB;
          cmd.wtag = 1'b1;
          sp_nxt = sp_r + 1'b1;
        end else begin
          cmd.op = DP_WRITE;
          cmd.wsel = WS_ALU;
          cmd.wtag = is_cmp;
          cmd.wsecond = 1'b1;
          sp_nxt = sp_r - 1'b1;
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      sp_r   <= '0;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      sp_r   <= sp_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_tvalid && in_tready) f_r <= in_func;
    status_r <= status_nxt;
    pv_r <= pv_nxt;
    if (st_r == S_OUT && out_free) begin
      out_status <= status_r;
      out_pvalid <= pv_r;
      out_pbool  <= pv_r & top_tag;
      out_pvalue <= pv_r ? top_value : '0;
      out_depth  <= DepthW'(sp_r);
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ovld_r;
  assign sp = sp_r;

  // a stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && !out_tready |=> ovld_r && $stable(out_status) && $stable(out_depth)
      && $stable(out_pvalue)) else $error("result changed while stalled");
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SpW'(StackDepth)) else $error("stack pointer out of range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_tready) else $error("accept while busy");
endmodule
`default_nettype wire

// File: rtl/core/rpn_stack_calculator.sv
// RPN stack calculator top level: controller plus datapath.
// Depends on rpn_pkg, rpn_ctrl, rpn_datapath.
//   channel | dir | tdata                     | tuser
//   in_     | in  | func[4:0], push_value[36:5] (40b) | -
//   out_    | out | status[2:0], print_valid[3], print_is_bool[4],
//           |     | print_value[36:5], stack_depth[43:37] (48b) | -
// Push, clear, drop and empty-stack cases are decided in decode; print/not/dup
// read the top first; binary ops read both operands; div/mod wait on the one-bit-per-
// cycle divider. One item at a time. Synchronous active-low reset empties
// the stack at once; the stack memory is not cleared. A stalled result beat
// holds in the output register; the next item runs and waits at its last step.
`default_nettype none
module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int unsigned StackDepth = DefStackDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // func, push_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // status, print_valid, print_is_bool,
                                       // print_value, stack_depth
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [$clog2(StackDepth+1)-1:0] sp;
  logic [DataW-1:0] top_value, pvalue;
  logic top_tag, pvalid, pbool;
  logic [StatW-1:0] status;
  logic [DepthW-1:0] depth;

  rpn_ctrl #(.StackDepth(StackDepth)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_func(in_tdata[4:0]),
    .out_tvalid, .out_tready, .out_status(status), .out_pvalid(pvalid),
    .out_pbool(pbool), .out_pvalue(pvalue), .out_depth(depth),
    .cmd, .sp, .stat, .top_value, .top_tag
  );

  rpn_datapath #(.StackDepth(StackDepth)) u_dp (
    .clk, .rst_n, .cmd, .in_func(in_tdata[4:0]), .in_value(in_tdata[36:5]),
    .sp, .stat, .top_value, .top_tag
  );

  assign out_tdata = {4'b0, depth, pvalue, pbool, pvalid, status};
endmodule
`default_nettype wire

// File: bench/rpn_stack_calculator_test.sv
// Testbench for rpn_stack_calculator: drives operation beats and checks every
// result beat against a behavioral stack calculator. Depends on rpn_pkg.
module rpn_stack_calculator_test import rpn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = DefStackDepth;

  typedef struct packed {
    logic [6:0]  depth;
    logic [31:0] value;
    logic        is_bool;
    logic        pvalid;
    logic [2:0]  status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  logic [31:0] calc_vals[Depth];
  logic        calc_tags[Depth];
  int          calc_sp = 0;
  result_t     pending[$];
  int          errors = 0;
  bit          quiet = 1'b0;
  int          stall_cnt = 0;

  rpn_stack_calculator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] mag(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic void calc_push(logic [31:0] v, logic t, inout logic [2:0] st);
    if (calc_sp >= Depth) st = ST_OVERFLOW;
    else begin
      calc_vals[calc_sp] = v;
      calc_tags[calc_sp] = t;
      calc_sp++;
    end
  endfunction

  function automatic result_t calc_step(logic [4:0] f, logic [31:0] pv);
    result_t r;
    logic [31:0] a, b, q;
    logic ta, tb;
    r = '0;
    r.status = ST_OK;
    case (f)
      F_PUSH: calc_push(pv, 1'b0, r.status);
      F_TRUE, F_FALSE: calc_push(32'(f == F_TRUE), 1'b1, r.status);
      F_NOT: begin
        if (calc_sp == 0) r.status = ST_EMPTY;
        else if (!calc_tags[calc_sp-1]) r.status = ST_NOT_BOOL;
        else calc_vals[calc_sp-1] = 32'(calc_vals[calc_sp-1] == 0);
      end
      F_PRINT: begin
        if (calc_sp != 0) begin
          r.pvalid = 1'b1;
          r.is_bool = calc_tags[calc_sp-1];
          r.value = calc_vals[calc_sp-1];
        end
      end
      F_CLEAR: calc_sp = 0;
      F_DROP: begin
        if (calc_sp == 0) r.status = ST_EMPTY;
        else calc_sp--;
      end
      F_DUP: begin
        if (calc_sp == 0) r.status = ST_EMPTY;
        else calc_push(calc_vals[calc_sp-1], calc_tags[calc_sp-1], r.status);
      end
      F_SWAP: begin
        if (calc_sp == 0) r.status = ST_EMPTY;
        else if (calc_sp == 1) begin
          calc_sp = 0;
          r.status = ST_EMPTY;
        end else begin
          a = calc_vals[calc_sp-1];
          ta = calc_tags[calc_sp-1];
          calc_vals[calc_sp-1] = calc_vals[calc_sp-2];
          calc_tags[calc_sp-1] = calc_tags[calc_sp-2];
          calc_vals[calc_sp-2] = a;
          calc_tags[calc_sp-2] = ta;
        end
      end
      F_ADD, F_SUB, F_MUL, F_DIV, F_MOD, F_LT, F_GT, F_LE, F_GE: begin
        if (calc_sp == 0) r.status = ST_EMPTY;
        else if (calc_tags[calc_sp-1]) r.status = ST_NOT_INT;
        else begin
          calc_sp--;
          b = calc_vals[calc_sp];
          if (calc_sp == 0) r.status = ST_EMPTY;
          else if (calc_tags[calc_sp-1]) r.status = ST_NOT_INT;
          else begin
            calc_sp--;
            a = calc_vals[calc_sp];
            case (f)
              F_ADD: calc_push(a + b, 1'b0, r.status);
              F_SUB: calc_push(a - b, 1'b0, r.status);
              F_MUL: calc_push(a * b, 1'b0, r.status);
              F_DIV, F_MOD: begin
                if (b == 0) r.status = ST_DIV_ZERO;
                else if (f == F_DIV) begin
                  q = mag(a) / mag(b);
                  calc_push((a[31] ^ b[31]) ? -q : q, 1'b0, r.status);
                end else begin
                  q = mag(a) % mag(b);
                  calc_push(a[31] ? -q : q, 1'b0, r.status);
                end
              end
              F_LT: calc_push(32'($signed(a) < $signed(b)), 1'b1, r.status);
              F_GT: calc_push(32'($signed(a) > $signed(b)), 1'b1, r.status);
              F_LE: calc_push(32'($signed(a) <= $signed(b)), 1'b1, r.status);
              default: calc_push(32'($signed(a) >= $signed(b)), 1'b1, r.status);
            endcase
          end
        end
      end
      F_EQ: begin
        if (calc_sp == 0) r.status = ST_EMPTY;
        else begin
          calc_sp--;
          b = calc_vals[calc_sp];
          tb = calc_tags[calc_sp];
          if (calc_sp == 0) r.status = ST_EMPTY;
          else begin
            calc_sp--;
            a = calc_vals[calc_sp];
            ta = calc_tags[calc_sp];
            calc_push(32'(a == b && ta == tb), 1'b1, r.status);
          end
        end
      end
      default: ;
    endcase
    r.depth = calc_sp[6:0];
    return r;
  endfunction

  task automatic send_op(logic [4:0] f, logic [31:0] pv = $urandom());
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, pv, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending.push_back(calc_step(f, pv));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (quiet) out_tready <= 1'b1;
      else if (stall_cnt != 0) begin
        out_tready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else if ($urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        stall_cnt <= $urandom_range(0, 10);
      end else out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[43:0];
      if (out_tdata[47:44] != 0) begin
        $error("out_tdata pad: expected 0, got %0h", out_tdata[47:44]);
        errors++;
      end
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        errors++;
      end else begin
        exp = pending.pop_front();
        if (got.status != exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, got.status);
          errors++;
        end
        if (got.pvalid != exp.pvalid) begin
          $error("print_valid: expected %0d, got %0d", exp.pvalid, got.pvalid);
          errors++;
        end
        if (got.is_bool != exp.is_bool) begin
          $error("print_is_bool: expected %0d, got %0d", exp.is_bool, got.is_bool);
          errors++;
        end
        if (got.value != exp.value) begin
          $error("print_value: expected %0h, got %0h", exp.value, got.value);
          errors++;
        end
        if (got.depth != exp.depth) begin
          $error("stack_depth: expected %0d, got %0d", exp.depth, got.depth);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_cases();
    logic [4:0] f;
    for (int i = F_NOT; i <= F_EQ; i++) begin
      f = 5'(i);
      send_op(f);
    end
    send_op(5'd19);
    send_op(5'd31);
  endtask

  task automatic test_directed_ops();
    send_op(F_PUSH, 32'h8000_0000);
    send_op(F_PUSH, 32'hffff_ffff);
    send_op(F_DIV);
    send_op(F_PRINT);
    send_op(F_PUSH, 32'h8000_0000);
    send_op(F_PUSH, 32'hffff_ffff);
    send_op(F_MOD);
    send_op(F_PUSH, 32'h7fff_ffff);
    send_op(F_PUSH, 0);
    send_op(F_DIV);
    send_op(F_TRUE);
    send_op(F_NOT);
    send_op(F_PRINT);
    send_op(F_ADD);
    send_op(F_PUSH, 5);
    send_op(F_FALSE);
    send_op(F_SWAP);
    send_op(F_SUB);
    send_op(F_PUSH, -7);
    send_op(F_PUSH, 2);
    send_op(F_MOD);
    send_op(F_NOT);
    send_op(F_CLEAR);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < Depth; i++) send_op(F_PUSH, $urandom());
    send_op(F_PUSH);
    send_op(F_TRUE);
    send_op(F_DUP);
    send_op(F_PRINT);
    drain();
    for (int i = 0; i < Depth + 1; i++) send_op(F_DROP);
    send_op(F_FALSE);
    send_op(F_SWAP);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 4) - 2;
      3: return $urandom_range(0, 40) - 20;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_random(int n);
    logic [4:0] f;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) send_op(F_PUSH, rand_value());
      else if (k < 36) send_op($urandom_range(0, 1) ? F_TRUE : F_FALSE);
      else if (k < 38) send_op(F_CLEAR - ($urandom_range(0, 3) != 0));
      else if (k < 40) send_op(5'($urandom_range(19, 31)));
      else if (k < 41 && calc_sp > 20) send_op(F_CLEAR);
      else begin
        f = 5'($urandom_range(F_NOT, F_EQ));
        if (f == F_CLEAR) f = F_PRINT;
        send_op(f);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_cases();
    test_directed_ops();
    drain();
    test_overflow();
    test_random(1375);
    drain();
    quiet = 1'b1;
    test_random(300);
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) $display("rpn_stack_calculator test passed");
    else $display("rpn_stack_calculator test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("rpn_stack_calculator test failed");
    $finish;
  end
endmodule

// File: rpn_stack_calculator.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_divider.sv
rtl/core/rpn_datapath.sv
rtl/core/rpn_ctrl.sv
rtl/core/rpn_stack_calculator.sv
bench/rpn_stack_calculator_test.sv
